// ===== rtl/status_led_pattern_generator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// status led pattern generator assertion macros
// concurrent check wrappers, removed when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_PATTERN_GENERATOR_UNIT_MACROS_SVH
`define STATUS_LED_PATTERN_GENERATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SLPG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define SLPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`else

`define SLPG_ASSERT_IMPL(label, clk, rst, ante, cons)

`define SLPG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/slpg_pkg.sv =====
// ----------------------------------------------------------------------------
// slpg_pkg
// shared types, constants and the pulse level table of the led pattern unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slpg_pkg;

   // field widths
   localparam int LEVEL_W    = 8;
   localparam int ADVANCE_W  = 10;
   localparam int MODE_W     = 4;
   localparam int PHASE_W    = 11;
   localparam int FLASH_W    = 10;
   localparam int CSR_IDX_W  = 2;

   // item kinds
   localparam logic KIND_TIME = 1'b0;
   localparam logic KIND_MODE = 1'b1;

   // modes
   localparam logic [MODE_W-1:0] MODE_OFF     = 4'd0;
   localparam logic [MODE_W-1:0] MODE_BLUE    = 4'd1;
   localparam logic [MODE_W-1:0] MODE_YELLOW  = 4'd2;
   localparam logic [MODE_W-1:0] MODE_GREEN   = 4'd3;
   localparam logic [MODE_W-1:0] MODE_PULSE   = 4'd4;
   localparam logic [MODE_W-1:0] MODE_PURPLE  = 4'd5;
   localparam logic [MODE_W-1:0] MODE_FLASH   = 4'd6;
   localparam logic [MODE_W-1:0] MODE_OFFLINE = 4'd7;
   localparam logic [MODE_W-1:0] MODE_WHITE   = 4'd8;
   localparam logic [MODE_W-1:0] MODE_LAST    = MODE_WHITE;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_LEVEL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_LEVEL = 2'd1;

   localparam logic [LEVEL_W-1:0] PEAK_LEVEL_RESET  = 8'd40;
   localparam logic [LEVEL_W-1:0] BLINK_LEVEL_RESET = 8'd8;

   // fixed colour levels
   localparam logic [LEVEL_W-1:0] TINT_LEVEL  = 8'd28;
   localparam logic [LEVEL_W-1:0] WHITE_LEVEL = 8'd16;
   localparam logic [LEVEL_W-1:0] PULSE_BASE  = 8'd2;
   localparam logic [LEVEL_W-1:0] SHOWN_RESET = 8'd1;

   // timing
   localparam int PULSE_PERIOD  = 2000;
   localparam int FLASH_ON      = 150;
   localparam int FLASH_OFF     = 150;
   localparam int FLASH_REPEATS = 3;
   localparam int FLASH_PERIOD  = FLASH_ON + FLASH_OFF;
   localparam int FLASH_LIMIT   = FLASH_REPEATS * FLASH_PERIOD;
   localparam int BLINK_ON      = 150;

   // pulse table
   localparam int COS_DEPTH = 256;
   localparam int COS_IDX_W = 8;
   localparam int TAB_W     = 9;
   // idx = phase * 256 / 2000 = (phase * 33555) >> 18, exact for phase < 2000
   localparam int IDX_SHIFT = 18;

   localparam longint Q30_ONE = 64'd1073741824;
   localparam longint Q30_PI  = 64'd3373259426;
   localparam longint Q30_TWO_PI = 64'd6746518852;
   localparam longint Q30_HALF_LSB = 64'd4194304;

   typedef struct packed {
      logic                 kind;
      logic [ADVANCE_W-1:0] advance_ms;
      logic [MODE_W-1:0]    new_mode;
   } item_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [PHASE_W-1:0] phase_ms;
      logic [FLASH_W-1:0] flash_ms;
   } pattern_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } colour_type;

   typedef logic [TAB_W-1:0] level_tab_type [COS_DEPTH];

   // cos in q30 for 0 <= x <= pi/2, taylor series to twelve terms
   function automatic longint cos_q30(input longint x);
      longint x2;
      longint t;
      longint acc;
      x2  = (x * x) >>> 30;
      t   = Q30_ONE;
      acc = Q30_ONE;
      t = ((t * x2) >>> 30) / 2;   acc = acc - t;
      t = ((t * x2) >>> 30) / 12;  acc = acc + t;
      t = ((t * x2) >>> 30) / 30;  acc = acc - t;
      t = ((t * x2) >>> 30) / 56;  acc = acc + t;
      t = ((t * x2) >>> 30) / 90;  acc = acc - t;
      t = ((t * x2) >>> 30) / 132; acc = acc + t;
      t = ((t * x2) >>> 30) / 182; acc = acc - t;
      t = ((t * x2) >>> 30) / 240; acc = acc + t;
      t = ((t * x2) >>> 30) / 306; acc = acc - t;
      t = ((t * x2) >>> 30) / 380; acc = acc + t;
      t = ((t * x2) >>> 30) / 462; acc = acc - t;
      t = ((t * x2) >>> 30) / 552; acc = acc + t;
      return acc;
   endfunction

   // raised cosine levels 0..256, evaluated at elaboration
   function automatic level_tab_type build_level_tab();
      level_tab_type tab;
      longint j;
      longint th;
      longint c;
      longint v;
      for (int i = 0; i < COS_DEPTH; i++) begin
         j  = (2 * i > COS_DEPTH) ? longint'(COS_DEPTH - i) : longint'(i);
         th = (j * Q30_TWO_PI) / COS_DEPTH;
         if (2 * th > Q30_PI) begin
            c = -cos_q30(Q30_PI - th);
         end else begin
            c = cos_q30(th);
         end
         v = Q30_ONE - c + Q30_HALF_LSB;
         if (v < 0) begin
            v = 0;
         end
         v = v >>> 23;
         if (v > 256) begin
            v = 256;
         end
         tab[i] = v[TAB_W-1:0];
      end
      return tab;
   endfunction

   localparam level_tab_type LEVEL_TAB = build_level_tab();

endpackage

`default_nettype wire

// ===== rtl/slpg_counters.sv =====
// ----------------------------------------------------------------------------
// slpg_counters
// mode register with the wrapping phase counter and saturating flash counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slpg_counters (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire slpg_pkg::item_type   item,
   output slpg_pkg::pattern_type     pattern_next
);
   import slpg_pkg::*;

   pattern_type pattern_ff;
   pattern_type pattern_in;

   logic [PHASE_W:0] phase_sum;
   logic [FLASH_W:0] flash_sum;

   always_comb begin
      pattern_in = pattern_ff;
      phase_sum  = {1'b0, pattern_ff.phase_ms} + {{(PHASE_W-ADVANCE_W+1){1'b0}}, item.advance_ms};
      flash_sum  = {1'b0, pattern_ff.flash_ms} + {1'b0, item.advance_ms};
      if (item.kind == KIND_MODE) begin
         if (item.new_mode <= MODE_LAST && item.new_mode != pattern_ff.mode) begin
            pattern_in.mode     = item.new_mode;
            pattern_in.phase_ms = '0;
            pattern_in.flash_ms = '0;
         end
      end else begin
         if (phase_sum >= (PHASE_W+1)'(PULSE_PERIOD)) begin
            pattern_in.phase_ms = PHASE_W'(phase_sum - (PHASE_W+1)'(PULSE_PERIOD));
         end else begin
            pattern_in.phase_ms = phase_sum[PHASE_W-1:0];
         end
         if (flash_sum > (FLASH_W+1)'(FLASH_LIMIT)) begin
            pattern_in.flash_ms = FLASH_W'(FLASH_LIMIT);
         end else begin
            pattern_in.flash_ms = flash_sum[FLASH_W-1:0];
         end
      end
   end

   assign pattern_next = pattern_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff.mode     <= MODE_OFF;
         pattern_ff.phase_ms <= '0;
         pattern_ff.flash_ms <= '0;
      end else if (advance) begin
         pattern_ff <= pattern_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/slpg_render.sv =====
// ----------------------------------------------------------------------------
// slpg_render
// colour of the current mode from the pattern counters and level registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slpg_render (
   input  wire slpg_pkg::pattern_type         pattern,
   input  wire logic [slpg_pkg::LEVEL_W-1:0]  peak_level,
   input  wire logic [slpg_pkg::LEVEL_W-1:0]  blink_level,
   output slpg_pkg::colour_type               colour
);
   import slpg_pkg::*;

   localparam int PROD_W = PHASE_W + 16;

   logic [PROD_W-1:0]        idx_prod;
   logic [COS_IDX_W-1:0]     idx;
   logic [TAB_W-1:0]         level;
   logic [LEVEL_W-1:0]       base;
   logic [LEVEL_W-1:0]       span;
   logic [TAB_W+LEVEL_W-1:0] scaled;
   logic [LEVEL_W-1:0]       pulse_red;
   logic                     flash_on;

   // phase x 33555 as shifts and adds
   always_comb begin
      idx_prod = (PROD_W'(pattern.phase_ms) << 15) + (PROD_W'(pattern.phase_ms) << 9)
               + (PROD_W'(pattern.phase_ms) << 8) + (PROD_W'(pattern.phase_ms) << 4)
               + (PROD_W'(pattern.phase_ms) << 1) + PROD_W'(pattern.phase_ms);
      idx      = idx_prod[IDX_SHIFT +: COS_IDX_W];
      level    = LEVEL_TAB[idx];
      base     = (peak_level < PULSE_BASE) ? peak_level : PULSE_BASE;
      span     = peak_level - base;
      scaled   = {{LEVEL_W{1'b0}}, level} * {{TAB_W{1'b0}}, span};
      pulse_red = base + scaled[8 +: LEVEL_W];
   end

   always_comb begin
      flash_on = 1'b0;
      for (int r = 0; r < FLASH_REPEATS; r++) begin
         if (pattern.flash_ms >= FLASH_W'(r * FLASH_PERIOD)
             && pattern.flash_ms < FLASH_W'(r * FLASH_PERIOD + FLASH_ON)) begin
            flash_on = 1'b1;
         end
      end
   end

   always_comb begin
      colour = '0;
      case (pattern.mode)
         MODE_BLUE: begin
            colour.blue = peak_level;
         end
         MODE_YELLOW: begin
            colour.red   = peak_level;
            colour.green = TINT_LEVEL;
         end
         MODE_GREEN: begin
            colour.green = peak_level;
         end
         MODE_PULSE: begin
            colour.red = pulse_red;
         end
         MODE_PURPLE: begin
            colour.red  = TINT_LEVEL;
            colour.blue = peak_level;
         end
         MODE_FLASH: begin
            colour.red = flash_on ? peak_level : '0;
         end
         MODE_OFFLINE: begin
            colour.red = (pattern.phase_ms < PHASE_W'(BLINK_ON)) ? blink_level : '0;
         end
         MODE_WHITE: begin
            colour.red   = WHITE_LEVEL;
            colour.green = WHITE_LEVEL;
            colour.blue  = WHITE_LEVEL;
         end
         default: begin
            colour = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/status_led_pattern_generator_unit.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_generator_unit
// status led mode and timing item in, rgb colour item out on change
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  req_kind, req_advance_ms, req_new_mode
//  rsp      out  rsp_valid/rsp_ready  rsp_red, rsp_green, rsp_blue
//  csr      in   csr_valid/csr_ready  csr_index, csr_data
//
//  one item per cycle while no result is held; a colour leaves after its
//  item is taken (input register, then a pass through counters and render)
//  synchronous reset clears mode and counters, loads shown colour and levels
//  with their reset values
//  a held result stalls input and counters only; csr_ready is always high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "status_led_pattern_generator_unit_macros.svh"

module status_led_pattern_generator_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_kind,
   input  wire logic [slpg_pkg::ADVANCE_W-1:0]    req_advance_ms,
   input  wire logic [slpg_pkg::MODE_W-1:0]       req_new_mode,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [slpg_pkg::LEVEL_W-1:0]           rsp_red,
   output logic [slpg_pkg::LEVEL_W-1:0]           rsp_green,
   output logic [slpg_pkg::LEVEL_W-1:0]           rsp_blue,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [slpg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [slpg_pkg::LEVEL_W-1:0]      csr_data
);
   import slpg_pkg::*;

   logic               in_valid_ff;
   logic               in_valid_in;
   item_type           in_item_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   colour_type         rsp_colour_ff;
   colour_type         shown_ff;
   logic [LEVEL_W-1:0] peak_level_ff;
   logic [LEVEL_W-1:0] peak_level_in;
   logic [LEVEL_W-1:0] blink_level_ff;
   logic [LEVEL_W-1:0] blink_level_in;

   logic               advance;
   logic               accept;
   logic               emit;
   pattern_type        pattern_next;
   colour_type         colour;

   slpg_counters u_counters (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (in_item_ff),
      .pattern_next (pattern_next)
   );

   slpg_render u_render (
      .pattern     (pattern_next),
      .peak_level  (peak_level_ff),
      .blink_level (blink_level_ff),
      .colour      (colour)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign emit      = advance && (in_item_ff.kind == KIND_TIME) && (colour != shown_ff);
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      peak_level_in  = peak_level_ff;
      blink_level_in = blink_level_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PEAK_LEVEL: begin
               peak_level_in = csr_data;
            end
            CSR_BLINK_LEVEL: begin
               blink_level_in = csr_data;
            end
            default: begin
               peak_level_in = peak_level_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         shown_ff.red   <= SHOWN_RESET;
         shown_ff.green <= SHOWN_RESET;
         shown_ff.blue  <= SHOWN_RESET;
         peak_level_ff  <= PEAK_LEVEL_RESET;
         blink_level_ff <= BLINK_LEVEL_RESET;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         peak_level_ff  <= peak_level_in;
         blink_level_ff <= blink_level_in;
         if (emit) begin
            shown_ff <= colour;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= {req_kind, req_advance_ms, req_new_mode};
      end
      if (emit) begin
         rsp_colour_ff <= colour;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_colour_ff.red;
   assign rsp_green = rsp_colour_ff.green;
   assign rsp_blue  = rsp_colour_ff.blue;

   `SLPG_ASSERT_NEXT(a_mode_item_silent, clock, reset,
      advance && (in_item_ff.kind == KIND_MODE), !rsp_valid_ff)
   `SLPG_ASSERT_IMPL(a_rsp_is_shown, clock, reset, rsp_valid_ff, rsp_colour_ff == shown_ff)
   `SLPG_ASSERT_IMPL(a_counter_range, clock, reset, advance,
      (pattern_next.phase_ms < PHASE_W'(PULSE_PERIOD))
      && (pattern_next.flash_ms <= FLASH_W'(FLASH_LIMIT)))

endmodule

`default_nettype wire

// ===== bench/status_led_pattern_generator_unit_test.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_generator_unit_test
// self-checking bench for the status led pattern generator: a short table of
// mode and time items, many with typed colours, then random phases under
// several level settings, checked by a cycle-free model of the pattern logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module status_led_pattern_generator_unit_test;
   import slpg_pkg::*;

   typedef enum logic [1:0] {
      BY_PREDICTOR,
      NO_COLOUR,
      TYPED_COLOUR
   } outcome_type;

   typedef enum logic [1:0] {
      PACE_NONE,
      PACE_FULL,
      PACE_SPARSE
   } pace_type;

   typedef struct packed {
      logic                 kind;
      logic [ADVANCE_W-1:0] advance_ms;
      logic [MODE_W-1:0]    new_mode;
      outcome_type          outcome;
      colour_type           colour;
   } step_row_type;

   localparam int DIRECTED_ROWS = 26;
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 260;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 4000;

   localparam step_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{KIND_TIME, 10'd0,    4'hF,         TYPED_COLOUR, '{8'd0,  8'd0,  8'd0}},
      '{KIND_MODE, 10'd0,    4'd12,        NO_COLOUR,    '{8'd0,  8'd0,  8'd0}},
      '{KIND_MODE, 10'd1023, MODE_OFF,     NO_COLOUR,    '{8'd0,  8'd0,  8'd0}},
      '{KIND_MODE, 10'd0,    MODE_BLUE,    NO_COLOUR,    '{8'd0,  8'd0,  8'd0}},
      '{KIND_TIME, 10'd1023, 4'h0,         TYPED_COLOUR, '{8'd0,  8'd0,  8'd40}},
      '{KIND_MODE, 10'd0,    MODE_YELLOW,  NO_COLOUR,    '{8'd0,  8'd0,  8'd0}},
      '{KIND_TIME, 10'd0,    4'h0,         TYPED_COLOUR, '{8'd40, 8'd28, 8'd0}},
      '{KIND_MODE, 10'd0,    MODE_GREEN,   NO_COLOUR,    '{8'd0,  8'd0,  8'd0}},
      '{KIND_TIME, 10'd1,    4'h0,         TYPED_COLOUR, '{8'd0,  8'd40, 8'd0}},
      '{KIND_MODE, 10'd0,    MODE_PURPLE,  NO_COLOUR,    '{8'd0,  8'd0,  8'd0}},
      '{KIND_TIME, 10'd1,    4'h0,         TYPED_COLOUR, '{8'd28, 8'd0,  8'd40}},
      '{KIND_MODE, 10'd0,    MODE_WHITE,   NO_COLOUR,    '{8'd0,  8'd0,  8'd0}},
      '{KIND_TIME, 10'd1,    4'h0,         TYPED_COLOUR, '{8'd16, 8'd16, 8'd16}},
      '{KIND_MODE, 10'd0,    MODE_PULSE,   NO_COLOUR,    '{8'd0,  8'd0,  8'd0}},
      '{KIND_TIME, 10'd0,    4'h0,         TYPED_COLOUR, '{8'd2,  8'd0,  8'd0}},
      '{KIND_TIME, 10'd1000, 4'h0,         TYPED_COLOUR, '{8'd40, 8'd0,  8'd0}},
      '{KIND_TIME, 10'd1023, 4'hA,         BY_PREDICTOR, '{8'd0,  8'd0,  8'd0}},
      '{KIND_MODE, 10'd0,    MODE_FLASH,   NO_COLOUR,    '{8'd0,  8'd0,  8'd0}},
      '{KIND_TIME, 10'd0,    4'h0,         TYPED_COLOUR, '{8'd40, 8'd0,  8'd0}},
      '{KIND_TIME, 10'd150,  4'h0,         TYPED_COLOUR, '{8'd0,  8'd0,  8'd0}},
      '{KIND_TIME, 10'd150,  4'h5,         BY_PREDICTOR, '{8'd0,  8'd0,  8'd0}},
      '{KIND_MODE, 10'd1023, MODE_FLASH,   NO_COLOUR,    '{8'd0,  8'd0,  8'd0}},
      '{KIND_TIME, 10'd1023, 4'h0,         BY_PREDICTOR, '{8'd0,  8'd0,  8'd0}},
      '{KIND_MODE, 10'd0,    MODE_OFFLINE, NO_COLOUR,    '{8'd0,  8'd0,  8'd0}},
      '{KIND_TIME, 10'd149,  4'h0,         TYPED_COLOUR, '{8'd8,  8'd0,  8'd0}},
      '{KIND_TIME, 10'd1,    4'h0,         TYPED_COLOUR, '{8'd0,  8'd0,  8'd0}}
   };

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic                 req_kind       = KIND_TIME;
   logic [ADVANCE_W-1:0] req_advance_ms = '0;
   logic [MODE_W-1:0]    req_new_mode   = MODE_OFF;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [LEVEL_W-1:0]   rsp_red;
   logic [LEVEL_W-1:0]   rsp_green;
   logic [LEVEL_W-1:0]   rsp_blue;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = CSR_PEAK_LEVEL;
   logic [LEVEL_W-1:0]   csr_data       = '0;

   // pattern model state
   int                 pulse_levels [COS_DEPTH];
   logic [MODE_W-1:0]  cur_mode;
   int                 phase_ms;
   int                 flash_ms;
   colour_type         shown;
   logic [LEVEL_W-1:0] lvl_max;
   logic [LEVEL_W-1:0] lvl_offline;

   colour_type expected_colours [$];
   pace_type   req_pace = PACE_FULL;
   pace_type   rsp_pace = PACE_SPARSE;

   int items_sent   = 0;
   int mode_reqs    = 0;
   int colours_seen = 0;
   int settings     = 1;
   int errors       = 0;

   status_led_pattern_generator_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_advance_ms (req_advance_ms),
      .req_new_mode   (req_new_mode),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #6 clock = ~clock;

   initial begin
      #8_000_000;
      $display("timeout waiting for the block");
      $display("Some tests failed");
      $finish;
   end

   function automatic int unsigned draw_gap(input pace_type pace);
      case (pace)
         PACE_FULL:   return $urandom_range(0, 18);
         PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
         default:     return 0;
      endcase
   endfunction

   // cosine in q30 for angles up to a quarter turn, twelve series terms
   function automatic longint cos_series(input longint x);
      longint sq;
      longint term;
      longint acc;
      sq   = (x * x) >>> 30;
      term = Q30_ONE;
      acc  = Q30_ONE;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * sq) >>> 30) / ((2 * k - 1) * (2 * k));
         acc  = (k % 2 == 1) ? acc - term : acc + term;
      end
      return acc;
   endfunction

   // advances the pattern for one item, returns 1 when a new colour goes out
   function automatic bit next_colour(input logic kind, input logic [ADVANCE_W-1:0] adv,
                                      input logic [MODE_W-1:0] nm, output colour_type col);
      int idx;
      int base;
      int level;
      col = '0;
      if (kind == KIND_MODE) begin
         if (nm <= MODE_LAST && nm != cur_mode) begin
            cur_mode = nm;
            phase_ms = 0;
            flash_ms = 0;
         end
         return 1'b0;
      end
      phase_ms = (phase_ms + int'(adv)) % PULSE_PERIOD;
      flash_ms = flash_ms + int'(adv);
      if (flash_ms > FLASH_LIMIT) begin
         flash_ms = FLASH_LIMIT;
      end
      case (cur_mode)
         MODE_BLUE:   col = '{8'd0, 8'd0, lvl_max};
         MODE_YELLOW: col = '{lvl_max, TINT_LEVEL, 8'd0};
         MODE_GREEN:  col = '{8'd0, lvl_max, 8'd0};
         MODE_PURPLE: col = '{TINT_LEVEL, 8'd0, lvl_max};
         MODE_WHITE:  col = '{WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL};
         MODE_PULSE: begin
            idx = (phase_ms * COS_DEPTH) / PULSE_PERIOD;
            if (idx >= COS_DEPTH) begin
               idx = COS_DEPTH - 1;
            end
            base  = (int'(lvl_max) < int'(PULSE_BASE)) ? int'(lvl_max) : int'(PULSE_BASE);
            level = base + ((pulse_levels[idx] * (int'(lvl_max) - base)) >>> 8);
            col.red = level[LEVEL_W-1:0];
         end
         MODE_FLASH: begin
            if (flash_ms < FLASH_LIMIT && (flash_ms % FLASH_PERIOD) < FLASH_ON) begin
               col.red = lvl_max;
            end
         end
         MODE_OFFLINE: begin
            if (phase_ms < BLINK_ON) begin
               col.red = lvl_offline;
            end
         end
         default: col = '0;
      endcase
      if (col == shown) begin
         return 1'b0;
      end
      shown = col;
      return 1'b1;
   endfunction

   // called at a rising edge; leaves the item on the bus after acceptance
   task automatic send_item(input logic kind, input logic [ADVANCE_W-1:0] adv,
                            input logic [MODE_W-1:0] nm, input outcome_type outcome,
                            input colour_type typed);
      int unsigned gap;
      bit          emits;
      colour_type  col;
      gap = draw_gap(req_pace);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_advance_ms <= adv;
      req_new_mode   <= nm;
      do @(posedge clock); while (!req_ready);
      emits = next_colour(kind, adv, nm, col);
      case (outcome)
         BY_PREDICTOR: if (emits) expected_colours.push_back(col);
         TYPED_COLOUR: expected_colours.push_back(typed);
         default: ;
      endcase
      items_sent++;
      if (kind == KIND_MODE) begin
         mode_reqs++;
      end
   endtask

   // stop sending, let every colour drain and the pipeline go quiet
   task automatic settle_block();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (expected_colours.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : colour_sink
      int unsigned hold;
      colour_type  got;
      colour_type  want;
      forever begin
         hold = draw_gap(rsp_pace);
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         got = '{red: rsp_red, green: rsp_green, blue: rsp_blue};
         colours_seen++;
         if (expected_colours.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected colour %0d/%0d/%0d at %0t",
                        got.red, got.green, got.blue, $realtime);
            end
         end else begin
            want = expected_colours.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
            begin
               errors++;
               if (errors <= 10) begin
                  $display("colour mismatch at %0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           $realtime, want.red, want.green, want.blue,
                           got.red, got.green, got.blue);
               end
            end
         end
      end
   end

   initial begin : stimulus
      longint             fold;
      longint             angle;
      longint             cosv;
      longint             lvl;
      logic               kind;
      logic [ADVANCE_W-1:0] adv;
      logic [MODE_W-1:0]  nm;
      logic [LEVEL_W-1:0] top;
      logic [LEVEL_W-1:0] dim;

      // raised cosine pulse levels
      for (int i = 0; i < COS_DEPTH; i++) begin
         fold  = (2 * i > COS_DEPTH) ? longint'(COS_DEPTH - i) : longint'(i);
         angle = (fold * Q30_TWO_PI) / COS_DEPTH;
         cosv  = (2 * angle > Q30_PI) ? -cos_series(Q30_PI - angle) : cos_series(angle);
         lvl   = Q30_ONE - cosv + (longint'(1) <<< 22);
         if (lvl < 0) begin
            lvl = 0;
         end
         lvl = lvl / (longint'(1) <<< 23);
         if (lvl > 256) begin
            lvl = 256;
         end
         pulse_levels[i] = int'(lvl);
      end

      cur_mode    = MODE_OFF;
      phase_ms    = 0;
      flash_ms    = 0;
      shown       = '{SHOWN_RESET, SHOWN_RESET, SHOWN_RESET};
      lvl_max     = PEAK_LEVEL_RESET;
      lvl_offline = BLINK_LEVEL_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_item(DIRECTED[r].kind, DIRECTED[r].advance_ms, DIRECTED[r].new_mode,
                   DIRECTED[r].outcome, DIRECTED[r].colour);
      end

      for (int p = 0; p < PHASES; p++) begin
         settle_block();
         case (p)
            0: begin top = 8'd255; dim = 8'd255; end
            1: begin top = 8'd0;   dim = 8'd0;   end
            2: begin top = 8'd1;   dim = 8'd128; end
            3: begin top = 8'd2;   dim = 8'd1;   end
            default: begin
               top = LEVEL_W'($urandom_range(0, 255));
               dim = LEVEL_W'($urandom_range(0, 255));
            end
         endcase
         csr_valid <= 1'b1;
         csr_index <= CSR_PEAK_LEVEL;
         csr_data  <= top;
         do @(posedge clock); while (!csr_ready);
         lvl_max = top;
         csr_index <= CSR_BLINK_LEVEL;
         csr_data  <= dim;
         do @(posedge clock); while (!csr_ready);
         lvl_offline = dim;
         csr_valid <= 1'b0;
         settings++;

         // first phase runs flat out on both sides
         if (p == 0) begin
            req_pace = PACE_NONE;
            rsp_pace = PACE_NONE;
         end else begin
            req_pace = pace_type'($urandom_range(0, 2));
            rsp_pace = pace_type'($urandom_range(0, 2));
         end

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 7) == 0) begin
               kind = KIND_MODE;
               adv  = ADVANCE_W'($urandom_range(0, 1023));
               nm   = ($urandom_range(0, 5) == 0) ? MODE_W'($urandom_range(9, 15))
                                                  : MODE_W'($urandom_range(0, MODE_LAST));
            end else begin
               kind = KIND_TIME;
               nm   = MODE_W'($urandom_range(0, 15));
               case ($urandom_range(0, 4))
                  0: adv = ADVANCE_W'($urandom_range(0, 20));
                  1: adv = ADVANCE_W'($urandom_range(0, 200));
                  2: adv = ADVANCE_W'($urandom_range(0, 1023));
                  3: adv = ADVANCE_W'($urandom_range(145, 155));
                  default: adv = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023;
               endcase
            end
            send_item(kind, adv, nm, BY_PREDICTOR, '0);
         end
      end

      settle_block();
      if (expected_colours.size() != 0) begin
         errors += expected_colours.size();
         $display("%0d expected colours never arrived", expected_colours.size());
      end
      $display("covered %0d items, %0d of them mode requests, under %0d level settings",
               items_sent, mode_reqs, settings);
      $display("checked %0d colour items with random stalls on both channels", colours_seen);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
